/* rtl/rbsi_pkg.sv */
package rbsi_pkg;

	localparam int unsigned FRAC_BITS_DEF = 16;
	localparam int unsigned IDX_W         = 3;

	localparam logic [IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [IDX_W-1:0] REG_DIR_X    = 3'd3;
	localparam logic [IDX_W-1:0] REG_DIR_Y    = 3'd4;
	localparam logic [IDX_W-1:0] REG_DIR_Z    = 3'd5;
	localparam logic [IDX_W-1:0] REG_LENGTH   = 3'd6;
	localparam logic [IDX_W-1:0] REG_COLL     = 3'd7;

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic signed [31:0] box_min_x;
		logic signed [31:0] box_min_y;
		logic signed [31:0] box_min_z;
		logic signed [31:0] box_max_x;
		logic signed [31:0] box_max_y;
		logic signed [31:0] box_max_z;
	} in_word_t;

	typedef struct packed {
		logic               hit;
		logic               origin_inside;
		logic signed [31:0] entry_dist;
		logic signed [31:0] hit_x;
		logic signed [31:0] hit_y;
		logic signed [31:0] hit_z;
	} out_word_t;

	// arithmetic shift right, rounding toward zero
	function automatic logic signed [79:0] trunc_shr(logic signed [79:0] p, int unsigned f);
		logic signed [79:0] bias;
		bias = (80'sd1 <<< f) - 80'sd1;
		if (p < 0) begin
			return (p + bias) >>> f;
		end
		return p >>> f;
	endfunction

	function automatic logic signed [31:0] sat_s32(logic signed [79:0] v);
		if (v > 80'(S32_MAX)) begin
			return S32_MAX;
		end
		if (v < 80'(S32_MIN)) begin
			return S32_MIN;
		end
		return v[31:0];
	endfunction

endpackage

/* rtl/rbsi_recip.sv */
module rbsi_recip #(
	parameter int unsigned FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [2:0]               recalc,
	input  logic signed [2:0][31:0]  dir,
	output logic signed [2:0][31:0]  rcp,
	output logic                     busy
);
	localparam int unsigned QW = 2 * FRAC_BITS + 1;
	localparam int unsigned CW = $clog2(QW);

	logic [2:0]               pend_q;
	logic                     run_q;
	logic [1:0]               ax_q;
	logic [CW-1:0]            cnt_q;
	logic [31:0]              rem_q;
	logic [QW-1:0]            quo_q;
	logic [31:0]              dv_q;
	logic                     neg_q;
	logic signed [2:0][31:0]  rcp_q;

	logic [1:0]   sel;
	logic [2:0]   clr;
	logic [31:0]  dsel;
	logic [31:0]  dmag;
	logic [32:0]  rs;
	logic         ge;
	logic [32:0]  rn;
	logic [QW-1:0] qf;
	logic [63:0]  q64;
	logic [31:0]  qres;

	always_comb begin
		sel = pend_q[0] ? 2'd0 : (pend_q[1] ? 2'd1 : 2'd2);
		clr = '0;
		if (!run_q && (|pend_q)) begin
			clr[sel] = 1'b1;
		end
		dsel = dir[sel];
		dmag = dsel[31] ? (~dsel + 32'd1) : dsel;
		rs   = {rem_q, (cnt_q == CW'(QW - 1))};
		ge   = rs >= {1'b0, dv_q};
		rn   = ge ? (rs - {1'b0, dv_q}) : rs;
		qf   = {quo_q[QW-2:0], ge};
		q64  = 64'(qf);
		if (!neg_q) begin
			qres = (q64 > 64'h7FFF_FFFF) ? rbsi_pkg::S32_MAX : q64[31:0];
		end else begin
			qres = (q64 > 64'h8000_0000) ? rbsi_pkg::S32_MIN : (~q64[31:0] + 32'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			run_q  <= 1'b0;
			ax_q   <= '0;
			cnt_q  <= '0;
			neg_q  <= 1'b0;
			rcp_q[0] <= 32'sd1 <<< FRAC_BITS;
			rcp_q[1] <= rbsi_pkg::S32_MAX;
			rcp_q[2] <= rbsi_pkg::S32_MAX;
		end else begin
			pend_q <= (pend_q & ~clr) | recalc;
			if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == '0) begin
					run_q      <= 1'b0;
					rcp_q[ax_q] <= qres;
				end
			end else if (|pend_q) begin
				if (dmag == '0) begin
					rcp_q[sel] <= rbsi_pkg::S32_MAX;
				end else begin
					run_q <= 1'b1;
					ax_q  <= sel;
					neg_q <= dsel[31];
					cnt_q <= CW'(QW - 1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (run_q) begin
			rem_q <= rn[31:0];
			quo_q <= qf;
		end else begin
			rem_q <= '0;
			quo_q <= '0;
			dv_q  <= dmag;
		end
	end

	assign rcp  = rcp_q;
	assign busy = run_q || (|pend_q);
endmodule

/* rtl/rbsi_slab.sv */
module rbsi_slab #(
	parameter int unsigned FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic signed [31:0] lo,
	input  logic signed [31:0] hi,
	input  logic signed [31:0] org,
	input  logic signed [31:0] rcp,
	output logic signed [31:0] near,
	output logic signed [31:0] far
);
	logic signed [32:0] d_lo_s1, d_hi_s1;
	logic signed [64:0] p_lo_s2, p_hi_s2;
	logic signed [31:0] t_lo_s3, t_hi_s3;
	logic signed [31:0] near_s4, far_s4;

	always_ff @(posedge clk) begin
		d_lo_s1 <= 33'(lo) - 33'(org);
		d_hi_s1 <= 33'(hi) - 33'(org);
		p_lo_s2 <= 65'(d_lo_s1) * 65'(rcp);
		p_hi_s2 <= 65'(d_hi_s1) * 65'(rcp);
		t_lo_s3 <= rbsi_pkg::sat_s32(rbsi_pkg::trunc_shr(80'(p_lo_s2), FRAC_BITS));
		t_hi_s3 <= rbsi_pkg::sat_s32(rbsi_pkg::trunc_shr(80'(p_hi_s2), FRAC_BITS));
		near_s4 <= (t_lo_s3 < t_hi_s3) ? t_lo_s3 : t_hi_s3;
		far_s4  <= (t_lo_s3 > t_hi_s3) ? t_lo_s3 : t_hi_s3;
	end

	assign near = near_s4;
	assign far  = far_s4;
endmodule

/* rtl/rbsi_hit.sv */
module rbsi_hit #(
	parameter int unsigned FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic signed [31:0]       tmin,
	input  logic signed [31:0]       tmax,
	input  logic signed [2:0][31:0]  org,
	input  logic signed [2:0][31:0]  dir,
	input  logic [30:0]              len,
	input  logic                     coll,
	output rbsi_pkg::out_word_t      result
);
	logic                     miss_s6;
	logic                     inside_s6;
	logic signed [31:0]       tmin_s6;
	logic signed [2:0][63:0]  p_s6;
	rbsi_pkg::out_word_t      res_s7;
	logic                     miss;
	logic signed [2:0][31:0]  loc;

	always_comb begin
		miss = (coll && tmax == '0) || (tmin > tmax) || (tmax < 0)
			|| (33'(tmin) > $signed({2'b00, len}));
		for (int i = 0; i < 3; i++) begin
			loc[i] = rbsi_pkg::sat_s32(80'($signed(org[i]))
				+ rbsi_pkg::trunc_shr(80'($signed(p_s6[i])), FRAC_BITS));
		end
	end

	always_ff @(posedge clk) begin
		miss_s6   <= miss;
		inside_s6 <= coll && (tmin < 0);
		tmin_s6   <= tmin;
		for (int i = 0; i < 3; i++) begin
			p_s6[i] <= 64'($signed(dir[i])) * 64'(tmin);
		end
		if (miss_s6) begin
			res_s7 <= '{1'b0, 1'b0, rbsi_pkg::S32_MAX, 32'sd0, 32'sd0, 32'sd0};
		end else if (inside_s6) begin
			res_s7 <= '{1'b1, 1'b1, 32'sd0, org[0], org[1], org[2]};
		end else begin
			res_s7 <= '{1'b1, 1'b0, tmin_s6, loc[0], loc[1], loc[2]};
		end
	end

	assign result = res_s7;
endmodule

/* rtl/ray_box_slab_intersection.sv */
// ray against axis-aligned box, slab test, fixed point
// the ray (origin, direction, length, collision mode) sits in registers
// written through cfg_we / cfg_idx / cfg_data; one box word enters when
// start is high and busy is low, one result word per box comes out on
// result with done high for a single cycle
// a new box every cycle while busy is low
// pipeline: difference, multiply by reciprocal, shift and saturate,
// per-axis min/max, slab combine, miss test and location multiply,
// location add and output register
// a direction write recomputes that axis reciprocal in a shared
// bit-serial divider, one axis at a time; while a recomputation is
// pending or running, busy is high and no box is taken
// reset loads origin 0, direction (1,0,0), maximum length, collision off,
// and empties the pipeline; done is never held off by the receiver
module ray_box_slab_intersection #(
	parameter int unsigned FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  rbsi_pkg::in_word_t             box,
	output logic                           done,
	output rbsi_pkg::out_word_t            result,
	input  logic                           cfg_we,
	input  logic [rbsi_pkg::IDX_W-1:0]     cfg_idx,
	input  logic [31:0]                    cfg_data
);
	localparam int unsigned DEPTH = 7;

	logic signed [2:0][31:0] org_q;
	logic signed [2:0][31:0] dir_q;
	logic [30:0]             len_q;
	logic                    coll_q;
	logic [DEPTH-1:0]        vld_q;
	logic [2:0]              recalc;
	logic signed [2:0][31:0] rcp;
	logic signed [2:0][31:0] near, far;
	logic signed [31:0]      tmin_s5, tmax_s5;
	logic signed [31:0]      a, b;
	logic signed [31:0]      c, e;

	always_comb begin
		recalc = '0;
		if (cfg_we) begin
			recalc[0] = (cfg_idx == rbsi_pkg::REG_DIR_X);
			recalc[1] = (cfg_idx == rbsi_pkg::REG_DIR_Y);
			recalc[2] = (cfg_idx == rbsi_pkg::REG_DIR_Z);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_q  <= '0;
			dir_q[0] <= 32'sd1 <<< FRAC_BITS;
			dir_q[1] <= '0;
			dir_q[2] <= '0;
			len_q  <= '1;
			coll_q <= 1'b0;
			vld_q  <= '0;
		end else begin
			vld_q <= {vld_q[DEPTH-2:0], start && !busy};
			if (cfg_we) begin
				case (cfg_idx)
					rbsi_pkg::REG_ORIGIN_X: org_q[0] <= cfg_data;
					rbsi_pkg::REG_ORIGIN_Y: org_q[1] <= cfg_data;
					rbsi_pkg::REG_ORIGIN_Z: org_q[2] <= cfg_data;
					rbsi_pkg::REG_DIR_X:    dir_q[0] <= cfg_data;
					rbsi_pkg::REG_DIR_Y:    dir_q[1] <= cfg_data;
					rbsi_pkg::REG_DIR_Z:    dir_q[2] <= cfg_data;
					rbsi_pkg::REG_LENGTH:   len_q    <= cfg_data[30:0];
					rbsi_pkg::REG_COLL:     coll_q   <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	rbsi_recip #(.FRAC_BITS(FRAC_BITS)) u_recip (
		.clk(clk), .arst_n(arst_n), .recalc(recalc), .dir(dir_q), .rcp(rcp), .busy(busy)
	);

	rbsi_slab #(.FRAC_BITS(FRAC_BITS)) u_slab_x (
		.clk(clk), .lo(box.box_min_x), .hi(box.box_max_x), .org(org_q[0]), .rcp(rcp[0]),
		.near(near[0]), .far(far[0])
	);
	rbsi_slab #(.FRAC_BITS(FRAC_BITS)) u_slab_y (
		.clk(clk), .lo(box.box_min_y), .hi(box.box_max_y), .org(org_q[1]), .rcp(rcp[1]),
		.near(near[1]), .far(far[1])
	);
	rbsi_slab #(.FRAC_BITS(FRAC_BITS)) u_slab_z (
		.clk(clk), .lo(box.box_min_z), .hi(box.box_max_z), .org(org_q[2]), .rcp(rcp[2]),
		.near(near[2]), .far(far[2])
	);

	// entry is the latest near plane, exit the earliest far plane
	always_comb begin
		a = ($signed(near[0]) > $signed(near[1])) ? near[0] : near[1];
		b = ($signed(far[0]) < $signed(far[1])) ? far[0] : far[1];
		c = (a > $signed(near[2])) ? a : near[2];
		e = (b < $signed(far[2])) ? b : far[2];
	end

	always_ff @(posedge clk) begin
		tmin_s5 <= c;
		tmax_s5 <= e;
	end

	rbsi_hit #(.FRAC_BITS(FRAC_BITS)) u_hit (
		.clk(clk), .tmin(tmin_s5), .tmax(tmax_s5), .org(org_q), .dir(dir_q),
		.len(len_q), .coll(coll_q), .result(result)
	);

	assign done = vld_q[DEPTH-1];

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, DEPTH))
		else $error("result word without matching start");

	a_miss_word: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.hit) |->
		(result.entry_dist == rbsi_pkg::S32_MAX && !result.origin_inside))
		else $error("miss word malformed");

	a_inside_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.origin_inside) |-> (result.hit && result.entry_dist == 0))
		else $error("inside flag without hit");

	a_dir_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(|recalc) |=> busy)
		else $error("direction write did not raise busy");
endmodule

/* sim/ray_box_slab_intersection_tb.sv */
module ray_box_slab_intersection_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = 16;
	localparam int IW = rbsi_pkg::IDX_W;
	localparam longint ONE = 64'sd65536;
	localparam longint MAXV = 64'sd2147483647;
	localparam longint MINV = -64'sd2147483648;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	rbsi_pkg::in_word_t box;
	logic done;
	rbsi_pkg::out_word_t result;
	logic cfg_we;
	logic [rbsi_pkg::IDX_W-1:0] cfg_idx;
	logic [31:0] cfg_data;

	ray_box_slab_intersection dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .box(box),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	typedef struct {
		rbsi_pkg::in_word_t b;
		bit coll;
		bit literal;
		rbsi_pkg::out_word_t want;
	} row_t;

	longint ray_org [3];
	longint ray_dir [3];
	longint ray_rcp [3];
	longint ray_len;
	bit coll_on;

	rbsi_pkg::out_word_t pending_hits [$];
	row_t dir_rows [$];
	int errors = 0;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	initial begin
		#1_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic longint sat32(longint v);
		if (v > MAXV) begin
			return MAXV;
		end
		if (v < MINV) begin
			return MINV;
		end
		return v;
	endfunction

	function automatic longint unsigned magn(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint recip(longint d);
		longint unsigned q;
		if (d == 0) begin
			return MAXV;
		end
		q = (64'd1 << (2 * FB)) / magn(d);
		if (d > 0) begin
			return q > 64'd2147483647 ? MAXV : longint'(q);
		end
		if (q > 64'd2147483648) begin
			return MINV;
		end
		return -longint'(q);
	endfunction

	function automatic longint mul_q(longint a, longint b);
		logic [127:0] p;
		p = ({64'd0, magn(a)} * {64'd0, magn(b)}) >> FB;
		return ((a < 0) != (b < 0)) ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	function automatic rbsi_pkg::out_word_t slab_test(rbsi_pkg::in_word_t b);
		longint lo [3];
		longint hi [3];
		longint ta, tb, tmin, tmax;
		rbsi_pkg::out_word_t r;
		bit miss;
		lo[0] = b.box_min_x; lo[1] = b.box_min_y; lo[2] = b.box_min_z;
		hi[0] = b.box_max_x; hi[1] = b.box_max_y; hi[2] = b.box_max_z;
		tmin = MINV * 4;
		tmax = MAXV * 4;
		for (int a = 0; a < 3; a++) begin
			ta = sat32(mul_q(lo[a] - ray_org[a], ray_rcp[a]));
			tb = sat32(mul_q(hi[a] - ray_org[a], ray_rcp[a]));
			if ((ta < tb ? ta : tb) > tmin) tmin = ta < tb ? ta : tb;
			if ((ta > tb ? ta : tb) < tmax) tmax = ta > tb ? ta : tb;
		end
		r = '0;
		r.entry_dist = rbsi_pkg::S32_MAX;
		miss = (coll_on && tmax == 0) || tmin > tmax || tmax < 0 || tmin > ray_len;
		if (!miss) begin
			r.hit = 1'b1;
			if (coll_on && tmin < 0) begin
				r.origin_inside = 1'b1;
				r.entry_dist = '0;
				r.hit_x = 32'(ray_org[0]);
				r.hit_y = 32'(ray_org[1]);
				r.hit_z = 32'(ray_org[2]);
			end else begin
				r.entry_dist = 32'(tmin);
				r.hit_x = 32'(sat32(ray_org[0] + mul_q(ray_dir[0], tmin)));
				r.hit_y = 32'(sat32(ray_org[1] + mul_q(ray_dir[1], tmin)));
				r.hit_z = 32'(sat32(ray_org[2] + mul_q(ray_dir[2], tmin)));
			end
		end
		return r;
	endfunction

	function automatic void ray_reset();
		for (int a = 0; a < 3; a++) begin
			ray_org[a] = 0;
			ray_dir[a] = a == 0 ? ONE : 0;
			ray_rcp[a] = recip(ray_dir[a]);
		end
		ray_len = MAXV;
		coll_on = 1'b0;
	endfunction

	// one register write, leaves cfg_we high; caller lowers it
	task automatic reg_write(logic [rbsi_pkg::IDX_W-1:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			rbsi_pkg::REG_ORIGIN_X, rbsi_pkg::REG_ORIGIN_Y, rbsi_pkg::REG_ORIGIN_Z:
				ray_org[idx] = longint'($signed(val));
			rbsi_pkg::REG_DIR_X, rbsi_pkg::REG_DIR_Y, rbsi_pkg::REG_DIR_Z: begin
				ray_dir[idx - rbsi_pkg::REG_DIR_X] = longint'($signed(val));
				ray_rcp[idx - rbsi_pkg::REG_DIR_X] = recip(ray_dir[idx - rbsi_pkg::REG_DIR_X]);
			end
			rbsi_pkg::REG_LENGTH: ray_len = longint'(val[30:0]);
			rbsi_pkg::REG_COLL: coll_on = val[0];
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (pending_hits.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// drives one box word and returns at the edge that takes it
	task automatic send_box(rbsi_pkg::in_word_t b, bit literal, rbsi_pkg::out_word_t want);
		bit taken;
		rbsi_pkg::out_word_t exp_word;
		start <= 1'b1;
		box <= b;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end
		exp_word = literal ? want : slab_test(b);
		pending_hits = {pending_hits, exp_word};
	endtask

	task automatic idle_gap(bit quiet);
		int n;
		int sel;
		sel = $urandom_range(0, 99);
		if (quiet || sel < 50) begin
			return;
		end
		n = sel < 90 ? $urandom_range(1, 3) : $urandom_range(10, 40);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_dir();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'hFFFF_FFFF;
			3: return rbsi_pkg::S32_MIN;
			4: return rbsi_pkg::S32_MAX;
			5: return 32'h0001_0000;
			6: return 32'hFFFF_0000;
			7: return $urandom;
			default: return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
		endcase
	endfunction

	function automatic rbsi_pkg::in_word_t rand_box();
		rbsi_pkg::in_word_t b;
		longint c, w, lo [3], hi [3], s, tmp;
		if ($urandom_range(0, 99) < 25) begin
			b.box_min_x = $urandom; b.box_min_y = $urandom; b.box_min_z = $urandom;
			b.box_max_x = $urandom; b.box_max_y = $urandom; b.box_max_z = $urandom;
			return b;
		end
		s = longint'($urandom_range(0, 8 << FB)) - ONE;
		for (int a = 0; a < 3; a++) begin
			c = ray_org[a] + mul_q(ray_dir[a], s)
				+ longint'($urandom_range(0, 1 << 18)) - (1 << 17);
			w = $urandom_range(0, 1 << 19);
			lo[a] = sat32(c - w);
			hi[a] = sat32(c + w);
			if ($urandom_range(0, 9) == 0) begin
				tmp = lo[a]; lo[a] = hi[a]; hi[a] = tmp;
			end
		end
		b.box_min_x = 32'(lo[0]); b.box_min_y = 32'(lo[1]); b.box_min_z = 32'(lo[2]);
		b.box_max_x = 32'(hi[0]); b.box_max_y = 32'(hi[1]); b.box_max_z = 32'(hi[2]);
		return b;
	endfunction

	function automatic void add_row(longint x0, longint y0, longint z0, longint x1,
		longint y1, longint z1, bit coll, bit literal, rbsi_pkg::out_word_t want);
		row_t r;
		r.b.box_min_x = 32'(x0); r.b.box_min_y = 32'(y0); r.b.box_min_z = 32'(z0);
		r.b.box_max_x = 32'(x1); r.b.box_max_y = 32'(y1); r.b.box_max_z = 32'(z1);
		r.coll = coll;
		r.literal = literal;
		r.want = want;
		dir_rows = {dir_rows, r};
	endfunction

	always @(posedge clk) begin
		rbsi_pkg::out_word_t want;
		if (arst_n && done) begin
			if (pending_hits.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result word %h", result);
			end else begin
				want = pending_hits.pop_front();
				if (result !== want) begin
					errors++;
					if (errors <= 10) begin
						$display("mismatch: hit %b/%b inside %b/%b dist %h/%h",
							want.hit, result.hit, want.origin_inside, result.origin_inside,
							want.entry_dist, result.entry_dist);
						$display("  loc exp %h %h %h got %h %h %h", want.hit_x, want.hit_y,
							want.hit_z, result.hit_x, result.hit_y, result.hit_z);
					end
				end
			end
		end
	end

	initial begin
		rbsi_pkg::out_word_t none;
		logic [31:0] v;
		bit quiet;
		none = '0;
		arst_n = 1'b0;
		start = 1'b0;
		box = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		ray_reset();

		// directed: reset ray along +x
		add_row(ONE, -ONE, -ONE, 2 * ONE, ONE, ONE, 0, 1,
			'{1'b1, 1'b0, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0});
		add_row(-2 * ONE, -ONE, -ONE, -ONE, ONE, ONE, 0, 1,
			'{1'b0, 1'b0, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0});
		add_row(MINV, MINV, MINV, MAXV, MAXV, MAXV, 0, 0, none);
		add_row(MAXV, MAXV, MAXV, MINV, MINV, MINV, 0, 0, none);
		add_row(0, 0, 0, 0, 0, 0, 0, 0, none);
		add_row(2 * ONE, ONE, -ONE, ONE, -ONE, ONE, 0, 0, none);
		add_row(-ONE, -ONE, -ONE, 0, ONE, ONE, 0, 0, none);
		add_row(ONE, ONE, ONE, 2 * ONE, 2 * ONE, 2 * ONE, 0, 0, none);
		add_row(-ONE, -ONE, -ONE, ONE, ONE, ONE, 0, 0, none);
		add_row(MAXV, 0, 0, MAXV, 0, 0, 0, 0, none);
		// collision mode: inside origin, exit exactly at origin
		add_row(-ONE, -ONE, -ONE, ONE, ONE, ONE, 1, 1,
			'{1'b1, 1'b1, 32'h0, 32'h0, 32'h0, 32'h0});
		add_row(-ONE, -ONE, -ONE, 0, ONE, ONE, 1, 1,
			'{1'b0, 1'b0, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0});
		add_row(ONE, -ONE, -ONE, 3 * ONE, ONE, ONE, 1, 0, none);
		add_row(MINV, MINV, MINV, MAXV, MAXV, MAXV, 1, 0, none);
		add_row(-3 * ONE, -ONE, -ONE, -2 * ONE, ONE, ONE, 1, 0, none);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].coll != coll_on) begin
				wait_idle();
				reg_write(rbsi_pkg::REG_COLL, {31'd0, dir_rows[i].coll});
				cfg_we <= 1'b0;
			end
			send_box(dir_rows[i].b, dir_rows[i].literal, dir_rows[i].want);
			idle_gap(1'b0);
		end

		for (int ph = 0; ph < 10; ph++) begin
			wait_idle();
			for (int a = 0; a < 3; a++) begin
				if (ph == 1) v = rbsi_pkg::S32_MIN;
				else if (ph == 2) v = rbsi_pkg::S32_MAX;
				else if (ph == 9) v = $urandom;
				else v = 32'($urandom_range(0, 1 << 25)) - 32'(1 << 24);
				reg_write(IW'(rbsi_pkg::REG_ORIGIN_X + a), v);
			end
			for (int a = 0; a < 3; a++) begin
				reg_write(IW'(rbsi_pkg::REG_DIR_X + a),
					ph == 0 && a == 1 ? rbsi_pkg::S32_MIN : pick_dir());
			end
			case (ph % 3)
				0: v = 32'hFFFF_FFFF;
				1: v = 32'd0;
				default: v = $urandom;
			endcase
			reg_write(rbsi_pkg::REG_LENGTH, v);
			reg_write(rbsi_pkg::REG_COLL, $urandom);
			cfg_we <= 1'b0;
			quiet = (ph == 3);
			for (int k = 0; k < 50; k++) begin
				if (ph == 4 && k == 25) wait_idle();
				send_box(rand_box(), 1'b0, none);
				idle_gap(quiet);
			end
		end

		start <= 1'b0;
		while (pending_hits.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
